// File: hw/rtl/wacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacc_pkg
// Shared types and constants of the wildcard address access check.
// ----------------------------------------------------------------------------
package wacc_pkg;

    localparam int CHAR_W  = 8;
    localparam int ENTRY_W = 4;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    localparam logic REQ_PATTERN = 1'b0;
    localparam logic REQ_ADDRESS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 1'b1;

    // address character travelling down the row of entry cells
    typedef struct packed {
        logic               vld;
        logic [CHAR_W-1:0]  chr;
        logic               start;
        logic               last;
        logic               found;
        logic [ENTRY_W-1:0] idx;
    } t_token;

    // pattern character write broadcast to all cells
    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] entry;
        logic [POS_W-1:0]   position;
        logic [CHAR_W-1:0]  chr;
        logic               last;
    } t_pat_wr;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/wacc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacc_req_if
// Request channel: one pattern or address character per beat.
// ----------------------------------------------------------------------------
interface wacc_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [wacc_pkg::ENTRY_W-1:0]     entry;
    logic [wacc_pkg::POS_W-1:0]       position;
    logic [wacc_pkg::CHAR_W-1:0]      char_code;
    logic                             last;

    modport source (output valid, req_type, entry, position, char_code, last,
                    input ready);
    modport sink   (input valid, req_type, entry, position, char_code, last,
                    output ready);
endinterface

// File: hw/rtl/wacc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacc_res_if
// Result channel: one access decision per beat.
// ----------------------------------------------------------------------------
interface wacc_res_if;
    logic                             valid;
    logic                             ready;
    logic                             authorised;
    logic                             matched;
    logic [wacc_pkg::ENTRY_W-1:0]     match_index;

    modport source (output valid, authorised, matched, match_index, input ready);
    modport sink   (input valid, authorised, matched, match_index, output ready);
endinterface

// File: hw/rtl/wacc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacc_cell
// One pattern entry: holds its characters, length and live position set,
// advances the set with the passing address character and forwards it.
// ----------------------------------------------------------------------------
module wacc_cell #(
    parameter int CELL_IDX = 0,
    parameter int PAT_LEN  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wacc_pkg::t_pat_wr             i_wr,
    input  logic [wacc_pkg::COUNT_W-1:0]  i_count,
    input  wacc_pkg::t_token              i_tok,
    output wacc_pkg::t_token              o_tok
);

    localparam int LEN_W = $clog2(PAT_LEN + 1);

    logic [wacc_pkg::CHAR_W-1:0] r_chr [PAT_LEN];
    logic [LEN_W-1:0]            r_len;
    logic [PAT_LEN:0]            r_act;
    logic [PAT_LEN:0]            n_act;
    wacc_pkg::t_token            r_tok;
    wacc_pkg::t_token            n_tok;

    logic                        wr_hit;
    logic [PAT_LEN-1:0]          star;
    logic [PAT_LEN-1:0]          step;
    logic [PAT_LEN-1:0]          live;
    logic [PAT_LEN:0]            start_set;
    logic [PAT_LEN:0]            cur;
    logic [PAT_LEN:0]            adv;
    logic                        in_use;
    logic                        hit;

    assign wr_hit = i_wr.en && (32'(i_wr.entry) == CELL_IDX);
    assign in_use = 32'(CELL_IDX) < 32'(i_count);

    always_comb begin
        for (int i = 0; i < PAT_LEN; i++) begin
            live[i] = 32'(i) < 32'(r_len);
            star[i] = (r_chr[i] == wacc_pkg::CHAR_STAR);
            step[i] = (r_chr[i] == wacc_pkg::CHAR_QMARK) ||
                      (wacc_pkg::fold_case(r_chr[i]) == wacc_pkg::fold_case(i_tok.chr));
        end
        // stars at the head of the pattern may be skipped from the start
        start_set    = '0;
        start_set[0] = 1'b1;
        for (int i = 0; i < PAT_LEN; i++) begin
            start_set[i+1] = start_set[i] & live[i] & star[i];
        end
        cur = i_tok.start ? start_set : r_act;
        adv = '0;
        for (int i = 0; i < PAT_LEN; i++) begin
            if (cur[i] && live[i]) begin
                if (star[i]) begin
                    adv[i] = 1'b1;
                end else if (step[i]) begin
                    adv[i+1] = 1'b1;
                end
            end
        end
        n_act    = adv;
        for (int i = 0; i < PAT_LEN; i++) begin
            n_act[i+1] = adv[i+1] | (n_act[i] & live[i] & star[i]);
        end
        hit = n_act[r_len];
    end

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.found && i_tok.last && in_use && hit) begin
            n_tok.found = 1'b1;
            n_tok.idx   = wacc_pkg::ENTRY_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.chr   <= n_tok.chr;
        r_tok.start <= n_tok.start;
        r_tok.last  <= n_tok.last;
        r_tok.found <= n_tok.found;
        r_tok.idx   <= n_tok.idx;
        if (!i_rst_n) begin
            r_act     <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= i_tok.vld;
            if (i_tok.vld) begin
                r_act <= n_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PAT_LEN; i++) begin
            if (wr_hit && (32'(i_wr.position) == i)) begin
                r_chr[i] <= i_wr.chr;
            end
        end
        if (wr_hit && i_wr.last) begin
            r_len <= LEN_W'(i_wr.position) + LEN_W'(1);
        end
    end

    assign o_tok = r_tok;

endmodule

// File: hw/rtl/wildcard_address_access_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_address_access_check
// Wildcard access list: a row of pattern entry cells checks an address
// character by character and reports whether the address may connect.
//
// i_req carries one character per beat. A pattern beat (req_type 0) writes
// one byte of one entry and completes in its accept cycle. An address beat
// (req_type 1) enters the cell row and walks one entry cell per cycle; the
// request channel is held off until it leaves the row, for the last address
// character until the decision has left the pending register for the output
// register. On the last address character the decision leaves the row into a
// pending register and then the output register, where o_res.valid rises.
// While o_res is stalled the pending register holds the decision and
// i_req.ready stays low; once the output register is free the next
// character is taken while the decision waits on o_res.
// Configuration writes on i_cfg_* take effect at once and are to be made by
// the user while the block is idle; the block does not enforce it. Reset
// clears the live position sets, list_mode to whitelist and pattern_count to
// zero; pattern bytes stay undefined until written. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module wildcard_address_access_check #(
    parameter int NUM_PATTERNS = 16,
    parameter int PAT_LEN      = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wacc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wacc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wacc_req_if.sink                          i_req,
    wacc_res_if.source                        o_res
);

    logic                          r_list_mode;
    logic [wacc_pkg::COUNT_W-1:0]  r_pattern_count;
    logic                          r_addr_start;
    wacc_pkg::t_token              r_tok_in;
    wacc_pkg::t_token              tok [NUM_PATTERNS+1];
    wacc_pkg::t_token              r_pend;
    logic                          r_out_vld;
    logic                          r_out_auth;
    logic                          r_out_matched;
    logic [wacc_pkg::ENTRY_W-1:0]  r_out_idx;
    wacc_pkg::t_pat_wr             pat_wr;
    logic [NUM_PATTERNS+1:0]       flight;
    logic                          busy;
    logic                          accept;
    logic                          addr_acc;
    logic                          pend_move;

    always_comb begin
        for (int k = 0; k <= NUM_PATTERNS; k++) begin
            flight[k] = tok[k].vld;
        end
        flight[NUM_PATTERNS+1] = r_pend.vld;
    end

    assign busy      = |flight;
    assign accept    = i_req.valid && i_req.ready;
    assign addr_acc  = accept && (i_req.req_type == wacc_pkg::REQ_ADDRESS);
    assign pend_move = r_pend.vld && (!r_out_vld || o_res.ready);

    assign i_req.ready = !busy;

    always_comb begin
        pat_wr.en       = accept && (i_req.req_type == wacc_pkg::REQ_PATTERN) &&
                          (32'(i_req.position) < PAT_LEN);
        pat_wr.entry    = i_req.entry;
        pat_wr.position = i_req.position;
        pat_wr.chr      = i_req.char_code;
        pat_wr.last     = i_req.last;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_mode     <= 1'b1;
            r_pattern_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wacc_pkg::CFG_LIST_MODE: begin
                    r_list_mode <= i_cfg_data[0];
                end
                wacc_pkg::CFG_PATTERN_COUNT: begin
                    r_pattern_count <= i_cfg_data;
                end
                default: begin
                    r_list_mode <= r_list_mode;
                end
            endcase
        end
    end

    // token entering the cell row
    always_ff @(posedge i_clk) begin
        if (addr_acc) begin
            r_tok_in.chr   <= i_req.char_code;
            r_tok_in.start <= r_addr_start;
            r_tok_in.last  <= i_req.last;
            r_tok_in.found <= 1'b0;
            r_tok_in.idx   <= '0;
        end
        if (!i_rst_n) begin
            r_addr_start <= 1'b1;
            r_tok_in.vld <= 1'b0;
        end else begin
            r_tok_in.vld <= addr_acc;
            if (addr_acc) begin
                r_addr_start <= i_req.last;
            end
        end
    end

    assign tok[0] = r_tok_in;

    for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_cell
        wacc_cell #(
            .CELL_IDX (k),
            .PAT_LEN  (PAT_LEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (pat_wr),
            .i_count (r_pattern_count),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1])
        );
    end

    // pending decision and output register
    always_ff @(posedge i_clk) begin
        if (tok[NUM_PATTERNS].vld && tok[NUM_PATTERNS].last) begin
            r_pend.chr   <= tok[NUM_PATTERNS].chr;
            r_pend.start <= tok[NUM_PATTERNS].start;
            r_pend.last  <= tok[NUM_PATTERNS].last;
            r_pend.found <= tok[NUM_PATTERNS].found;
            r_pend.idx   <= tok[NUM_PATTERNS].idx;
        end
        if (!i_rst_n) begin
            r_pend.vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (tok[NUM_PATTERNS].vld && tok[NUM_PATTERNS].last) begin
                r_pend.vld <= 1'b1;
            end else if (pend_move) begin
                r_pend.vld <= 1'b0;
            end
            if (pend_move) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_auth    <= (r_pattern_count == '0) || (r_pend.found == r_list_mode);
            r_out_matched <= r_pend.found;
            r_out_idx     <= r_pend.found ? r_pend.idx : '0;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.authorised  = r_out_auth;
    assign o_res.matched     = r_out_matched;
    assign o_res.match_index = r_out_idx;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(flight))
        else $error("more than one token in the cell row");

    a_addr_enters_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        addr_acc |=> tok[0].vld)
        else $error("accepted address beat did not enter the cell row");

    a_out_from_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_pend.vld))
        else $error("result shown without a pending decision");

    a_match_follows_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_matched) |-> (r_out_auth == r_list_mode))
        else $error("matched result disagrees with list mode");

    a_no_match_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_matched) |-> (r_out_idx == '0))
        else $error("match index set without a match");

endmodule

// File: tb/wacc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wacc_tb_pkg
// Beat types and the access decision scoreboard of the wildcard access check
// bench. The scoreboard keeps its own copy of the pattern table, the live
// position set of every entry and the two registers. Every accepted request
// beat updates that copy, each last address character adds a decision due,
// and each decision beat from the block is compared with the oldest one due.
// ----------------------------------------------------------------------------
package wacc_tb_pkg;

    localparam int NUM_ENTRIES = 16;
    localparam int ENTRY_LEN   = 32;

    typedef struct packed {
        logic                         req_type;
        logic [wacc_pkg::ENTRY_W-1:0] entry;
        logic [wacc_pkg::POS_W-1:0]   position;
        logic [wacc_pkg::CHAR_W-1:0]  char_code;
        logic                         last;
    } t_req_beat;

    typedef struct packed {
        logic                         authorised;
        logic                         matched;
        logic [wacc_pkg::ENTRY_W-1:0] match_index;
    } t_decision;

    class access_scoreboard;
        bit [wacc_pkg::CHAR_W-1:0]  pat_chars [NUM_ENTRIES][ENTRY_LEN];
        bit [5:0]                   pat_len [NUM_ENTRIES];
        bit [ENTRY_LEN:0]           live_pos [NUM_ENTRIES];
        bit                         addr_fresh;
        bit                         list_mode;
        bit [wacc_pkg::COUNT_W-1:0] pattern_count;
        t_decision                  decisions_due [$];
        int                         errors;
        int                         shown;

        function new();
            addr_fresh    = 1'b1;
            list_mode     = 1'b1;
            pattern_count = '0;
            errors        = 0;
            shown         = 0;
            foreach (live_pos[e]) begin
                live_pos[e] = '0;
            end
        endfunction

        function void set_register(logic [wacc_pkg::CFG_IDX_W-1:0]  idx,
                                   logic [wacc_pkg::CFG_DATA_W-1:0] data);
            if (idx == wacc_pkg::CFG_LIST_MODE) begin
                list_mode = data[0];
            end else if (idx == wacc_pkg::CFG_PATTERN_COUNT) begin
                pattern_count = data[wacc_pkg::COUNT_W-1:0];
            end
        endfunction

        function bit [wacc_pkg::CHAR_W-1:0] upcase(bit [wacc_pkg::CHAR_W-1:0] c);
            if (c >= wacc_pkg::CHAR_LC_A && c <= wacc_pkg::CHAR_LC_Z) begin
                return c - wacc_pkg::CASE_DIFF;
            end
            return c;
        endfunction

        function int used_len(int e);
            return (pat_len[e] > ENTRY_LEN) ? ENTRY_LEN : int'(pat_len[e]);
        endfunction

        // a live star also opens the position behind it
        function bit [ENTRY_LEN:0] spread_stars(int e, bit [ENTRY_LEN:0] s);
            for (int i = 0; i < used_len(e); i++) begin
                if (s[i] && pat_chars[e][i] == wacc_pkg::CHAR_STAR) begin
                    s[i+1] = 1'b1;
                end
            end
            return s;
        endfunction

        function bit [ENTRY_LEN:0] step_live(int e, bit [ENTRY_LEN:0] s,
                                             bit [wacc_pkg::CHAR_W-1:0] c);
            bit [ENTRY_LEN:0]          nxt;
            bit [wacc_pkg::CHAR_W-1:0] p;
            nxt = '0;
            for (int i = 0; i < used_len(e); i++) begin
                if (s[i]) begin
                    p = pat_chars[e][i];
                    if (p == wacc_pkg::CHAR_STAR) begin
                        nxt[i] = 1'b1;
                    end else if (p == wacc_pkg::CHAR_QMARK || upcase(p) == upcase(c)) begin
                        nxt[i+1] = 1'b1;
                    end
                end
            end
            return spread_stars(e, nxt);
        endfunction

        function void take_beat(t_req_beat b);
            int               n;
            int               hit;
            bit [ENTRY_LEN:0] s;
            t_decision        d;
            if (b.req_type == wacc_pkg::REQ_PATTERN) begin
                pat_chars[b.entry][b.position] = b.char_code;
                if (b.last) begin
                    pat_len[b.entry] = 6'(b.position) + 6'd1;
                end
                return;
            end
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                s = addr_fresh ? spread_stars(e, (ENTRY_LEN+1)'(1)) : live_pos[e];
                live_pos[e] = step_live(e, s, b.char_code);
            end
            addr_fresh = 1'b0;
            if (!b.last) begin
                return;
            end
            addr_fresh = 1'b1;
            n = (pattern_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(pattern_count);
            hit = -1;
            for (int e = 0; e < n && hit < 0; e++) begin
                if (live_pos[e][used_len(e)]) begin
                    hit = e;
                end
            end
            if (n == 0) begin
                d.authorised  = 1'b1;
                d.matched     = 1'b0;
                d.match_index = '0;
            end else begin
                d.authorised  = (hit >= 0) ? list_mode : !list_mode;
                d.matched     = (hit >= 0);
                d.match_index = (hit >= 0) ? (wacc_pkg::ENTRY_W)'(hit) : '0;
            end
            decisions_due.push_back(d);
        endfunction

        function void check_decision(t_decision got);
            t_decision want;
            if (decisions_due.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected decision beat: authorised=%0b matched=%0b index=%0d",
                             got.authorised, got.matched, got.match_index);
                end
                return;
            end
            want = decisions_due.pop_front();
            if (got.authorised !== want.authorised || got.matched !== want.matched ||
                got.match_index !== want.match_index) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("decision mismatch: expected authorised=%0b matched=%0b index=%0d,",
                             want.authorised, want.matched, want.match_index);
                    $display("    got authorised=%0b matched=%0b index=%0d",
                             got.authorised, got.matched, got.match_index);
                end
            end
        endfunction
    endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the wildcard address access check. A directed part fills every
// entry and tries case folding, the zero byte, 0xff, '?', '*', no patterns,
// an oversized count and both list modes. Random phases then set the two
// registers and mix whole pattern writes, addresses built to match stored
// patterns, random addresses and stray pattern bytes, some of them landing
// inside an address. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT        = 600000;
    localparam int DRAIN        = wacc_tb_pkg::NUM_ENTRIES + 8;
    localparam int RANDOM_ITEMS = 1900;
    localparam int PHASE_ITEMS  = 150;
    localparam logic [wacc_pkg::CHAR_W-1:0] UC_A = wacc_pkg::CHAR_LC_A - wacc_pkg::CASE_DIFF;
    localparam logic [wacc_pkg::CHAR_W-1:0] UC_Z = wacc_pkg::CHAR_LC_Z - wacc_pkg::CASE_DIFF;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [wacc_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [wacc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    wacc_req_if req_bus ();
    wacc_res_if res_bus ();

    wildcard_address_access_check #(
        .NUM_PATTERNS (wacc_tb_pkg::NUM_ENTRIES),
        .PAT_LEN      (wacc_tb_pkg::ENTRY_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_res      (res_bus)
    );

    wacc_tb_pkg::access_scoreboard      board;
    logic [wacc_tb_pkg::ENTRY_LEN-1:0]  filled [wacc_tb_pkg::NUM_ENTRIES];
    logic [wacc_pkg::CHAR_W-1:0]        addr_chars [$];
    int                                 items_sent = 0;
    int                                 cycles     = 0;
    bit                                 req_quiet  = 1'b0;
    bit                                 res_quiet  = 1'b0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [wacc_pkg::CHAR_W-1:0] letter();
        logic [wacc_pkg::CHAR_W-1:0] base;
        base = $urandom_range(0, 1) ? wacc_pkg::CHAR_LC_A : UC_A;
        return base + (wacc_pkg::CHAR_W)'($urandom_range(0, 3));
    endfunction

    function automatic logic [wacc_pkg::CHAR_W-1:0] address_char();
        if ($urandom_range(0, 99) < 55) begin
            return letter();
        end
        return (wacc_pkg::CHAR_W)'($urandom_range(0, 255));
    endfunction

    function automatic logic [wacc_pkg::CHAR_W-1:0] pattern_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            return wacc_pkg::CHAR_STAR;
        end else if (r < 32) begin
            return wacc_pkg::CHAR_QMARK;
        end else if (r < 75) begin
            return letter();
        end
        return (wacc_pkg::CHAR_W)'($urandom_range(0, 255));
    endfunction

    function automatic logic [wacc_pkg::CHAR_W-1:0] flip_case(
        logic [wacc_pkg::CHAR_W-1:0] c);
        if ($urandom_range(0, 1) == 0) begin
            return c;
        end else if (c >= wacc_pkg::CHAR_LC_A && c <= wacc_pkg::CHAR_LC_Z) begin
            return c - wacc_pkg::CASE_DIFF;
        end else if (c >= UC_A && c <= UC_Z) begin
            return c + wacc_pkg::CASE_DIFF;
        end
        return c;
    endfunction

    // entered at a falling edge, returns at the falling edge after the beat
    task automatic send_beat(input wacc_tb_pkg::t_req_beat b);
        int gap;
        gap = req_quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.req_type  = b.req_type;
        req_bus.entry     = b.entry;
        req_bus.position  = b.position;
        req_bus.char_code = b.char_code;
        req_bus.last      = b.last;
        req_bus.valid     = 1'b1;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        board.take_beat(b);
        if (b.req_type == wacc_pkg::REQ_PATTERN) begin
            filled[b.entry][b.position] = 1'b1;
        end
        items_sent++;
        if ($urandom_range(0, 39) == 0) begin
            req_quiet = !req_quiet;
        end
        @(negedge i_clk);
    endtask

    task automatic settle();
        req_bus.valid = 1'b0;
        while (board.decisions_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [wacc_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [wacc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        board.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic put_pattern(input int e, input int len);
        wacc_tb_pkg::t_req_beat b;
        for (int p = 0; p < len; p++) begin
            b.req_type  = wacc_pkg::REQ_PATTERN;
            b.entry     = (wacc_pkg::ENTRY_W)'(e);
            b.position  = (wacc_pkg::POS_W)'(p);
            b.char_code = pattern_char();
            b.last      = (p == len - 1);
            send_beat(b);
        end
    endtask

    // stray byte; it only ends a pattern when all lower positions hold data
    task automatic put_noise_pattern();
        wacc_tb_pkg::t_req_beat            b;
        logic [wacc_tb_pkg::ENTRY_LEN-1:0] low;
        b.req_type  = wacc_pkg::REQ_PATTERN;
        b.entry     = (wacc_pkg::ENTRY_W)'($urandom_range(0, wacc_tb_pkg::NUM_ENTRIES - 1));
        b.position  = (wacc_pkg::POS_W)'($urandom_range(0, wacc_tb_pkg::ENTRY_LEN - 1));
        b.char_code = (wacc_pkg::CHAR_W)'($urandom_range(0, 255));
        low         = ((wacc_tb_pkg::ENTRY_LEN)'(1) << b.position) -
                      (wacc_tb_pkg::ENTRY_LEN)'(1);
        b.last      = ($urandom_range(0, 3) == 0) && ((filled[b.entry] & low) == low);
        send_beat(b);
    endtask

    task automatic put_address(input bit mix_writes);
        wacc_tb_pkg::t_req_beat b;
        for (int i = 0; i < addr_chars.size(); i++) begin
            if (mix_writes && $urandom_range(0, 11) == 0) begin
                put_noise_pattern();
            end
            b.req_type  = wacc_pkg::REQ_ADDRESS;
            b.entry     = (wacc_pkg::ENTRY_W)'($urandom_range(0, wacc_tb_pkg::NUM_ENTRIES - 1));
            b.position  = (wacc_pkg::POS_W)'($urandom_range(0, wacc_tb_pkg::ENTRY_LEN - 1));
            b.char_code = addr_chars[i];
            b.last      = (i == addr_chars.size() - 1);
            send_beat(b);
        end
    endtask

    task automatic make_match(input int e);
        logic [wacc_pkg::CHAR_W-1:0] p;
        int                          run;
        int                          pick;
        addr_chars.delete();
        for (int i = 0; i < board.used_len(e); i++) begin
            p = board.pat_chars[e][i];
            if (p == wacc_pkg::CHAR_STAR) begin
                run = $urandom_range(0, 3);
                repeat (run) addr_chars.push_back(address_char());
            end else if (p == wacc_pkg::CHAR_QMARK) begin
                addr_chars.push_back(address_char());
            end else begin
                addr_chars.push_back(flip_case(p));
            end
        end
        if (addr_chars.size() == 0) begin
            addr_chars.push_back(address_char());
        end
        if ($urandom_range(0, 6) == 0) begin
            pick = $urandom_range(0, addr_chars.size() - 1);
            addr_chars[pick] = (wacc_pkg::CHAR_W)'($urandom_range(0, 255));
        end
    endtask

    task automatic make_random_address();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
        addr_chars.delete();
        repeat (len) addr_chars.push_back(address_char());
    endtask

    task automatic one_transaction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) begin
            put_pattern($urandom_range(0, wacc_tb_pkg::NUM_ENTRIES - 1),
                        ($urandom_range(0, 99) < 85) ?
                            $urandom_range(1, 6) :
                            $urandom_range(1, wacc_tb_pkg::ENTRY_LEN));
        end else if (r < 75) begin
            make_match($urandom_range(0, wacc_tb_pkg::NUM_ENTRIES - 1));
            put_address(1'b1);
        end else if (r < 88) begin
            make_random_address();
            put_address(1'b1);
        end else begin
            put_noise_pattern();
        end
    endtask

    // decision side: random stalls, check every beat taken
    initial begin : decision_side
        int                     wait_n;
        wacc_tb_pkg::t_decision got;
        res_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            wait_n = res_quiet ? 0 : $urandom_range(0, 11);
            if (wait_n > 0) begin
                res_bus.ready = 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            res_bus.ready = 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
            got.authorised  = res_bus.authorised;
            got.matched     = res_bus.matched;
            got.match_index = res_bus.match_index;
            board.check_decision(got);
            if ($urandom_range(0, 39) == 0) begin
                res_quiet = !res_quiet;
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        wacc_tb_pkg::t_req_beat      b;
        logic [wacc_pkg::CHAR_W-1:0] c;
        bit                          mode_bit;
        int                          count_val;
        int                          directed_total;
        int                          ph;
        int                          start;
        board = new();
        req_bus.valid     = 1'b0;
        req_bus.req_type  = wacc_pkg::REQ_PATTERN;
        req_bus.entry     = '0;
        req_bus.position  = '0;
        req_bus.char_code = '0;
        req_bus.last      = 1'b0;
        foreach (filled[e]) begin
            filled[e] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one-byte pattern in every entry
        for (int e = 0; e < wacc_tb_pkg::NUM_ENTRIES; e++) begin
            case (e)
                0:       c = wacc_pkg::CHAR_LC_A;
                1:       c = UC_Z;
                2:       c = 8'h00;
                3:       c = 8'hFF;
                14:      c = wacc_pkg::CHAR_QMARK;
                15:      c = wacc_pkg::CHAR_STAR;
                default: c = UC_A + (wacc_pkg::CHAR_W)'(e);
            endcase
            b.req_type  = wacc_pkg::REQ_PATTERN;
            b.entry     = (wacc_pkg::ENTRY_W)'(e);
            b.position  = '0;
            b.char_code = c;
            b.last      = 1'b1;
            send_beat(b);
        end
        // no patterns in use
        addr_chars = '{UC_A};
        put_address(1'b0);
        settle();
        write_reg(wacc_pkg::CFG_LIST_MODE, 5'd1);
        write_reg(wacc_pkg::CFG_PATTERN_COUNT, 5'd31);
        addr_chars = '{UC_A};
        put_address(1'b0);
        addr_chars = '{8'h00};
        put_address(1'b0);
        addr_chars = '{8'hFF};
        put_address(1'b0);
        addr_chars = '{wacc_pkg::CHAR_LC_Z, wacc_pkg::CHAR_LC_Z};
        put_address(1'b0);
        settle();
        write_reg(wacc_pkg::CFG_LIST_MODE, 5'd0);
        write_reg(wacc_pkg::CFG_PATTERN_COUNT, 5'd14);
        addr_chars = '{wacc_pkg::CHAR_LC_Z, wacc_pkg::CHAR_LC_Z};
        put_address(1'b0);
        addr_chars = '{wacc_pkg::CHAR_LC_Z};
        put_address(1'b0);
        directed_total = items_sent;

        ph = 0;
        while (items_sent - directed_total < RANDOM_ITEMS) begin
            case (ph)
                0:       begin mode_bit = 1'b1; count_val = 16; end
                1:       begin mode_bit = 1'b0; count_val = 16; end
                2:       begin mode_bit = 1'b1; count_val = 31; end
                3:       begin mode_bit = 1'b0; count_val = 0;  end
                4:       begin mode_bit = 1'b1; count_val = 1;  end
                5:       begin mode_bit = 1'b0; count_val = 17; end
                default: begin
                    mode_bit  = $urandom_range(0, 1);
                    count_val = $urandom_range(0, 31);
                end
            endcase
            settle();
            write_reg(wacc_pkg::CFG_LIST_MODE, {4'($urandom_range(0, 15)), mode_bit});
            write_reg(wacc_pkg::CFG_PATTERN_COUNT, (wacc_pkg::CFG_DATA_W)'(count_val));
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                one_transaction();
            end
            ph++;
        end

        settle();
        if (board.errors == 0 && board.decisions_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/wacc_pkg.sv
hw/rtl/wacc_req_if.sv
hw/rtl/wacc_res_if.sv
hw/rtl/wacc_cell.sv
hw/rtl/wildcard_address_access_check.sv
tb/wacc_tb_pkg.sv
tb/tb_top.sv
